@@ rtl/thick_line_rasterizer_macros.svh @@
// Assertion helpers, clocked on i_clk and held off during reset.
`ifndef THICK_LINE_RASTERIZER_MACROS_SVH
`define THICK_LINE_RASTERIZER_MACROS_SVH

// Property that must hold at every edge.
`define TLR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that implies another one in the next cycle.
`define TLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tlr_pkg.sv @@
package tlr_pkg;

    localparam int IMAGE_SIDE       = 64;
    localparam int MAX_BRUSH_RADIUS = 15;

    localparam int PIX_DEPTH = IMAGE_SIDE * IMAGE_SIDE;
    localparam int ADDR_W    = $clog2(PIX_DEPTH);
    localparam int REQ_W     = 2;
    localparam int COORD_W   = 6;
    localparam int RAD_IN_W  = 4;
    localparam int COLOR_W   = 16;
    localparam int RAD_W     = $clog2(MAX_BRUSH_RADIUS + 1);
    localparam int OFS_W     = RAD_W + 1;
    localparam int SQ_W      = 2 * RAD_W + 1;
    localparam int PIX_W     = 10;
    localparam int ERR_W     = 9;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR = 2'd0,
        REQ_LINE  = 2'd1,
        REQ_READ  = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        S_WIPE,
        S_IDLE,
        S_CLEAR,
        S_DISC,
        S_READ,
        S_DONE
    } t_state;

    function automatic logic [SQ_W-1:0] f_square(input logic signed [OFS_W-1:0] v);
        logic signed [2*OFS_W-1:0] p;
        p = (2*OFS_W)'(v) * (2*OFS_W)'(v);
        return SQ_W'(p);
    endfunction

endpackage

@@ rtl/tlr_if.sv @@
interface tlr_req_if;
    import tlr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REQ_W-1:0]      req_type;
    logic [COORD_W-1:0]    start_x;
    logic [COORD_W-1:0]    start_y;
    logic [COORD_W-1:0]    end_x;
    logic [COORD_W-1:0]    end_y;
    logic [RAD_IN_W-1:0]   brush_radius;
    logic [COLOR_W-1:0]    draw_color;
    logic [COORD_W-1:0]    read_x;
    logic [COORD_W-1:0]    read_y;

    modport source (
        output valid, req_type, start_x, start_y, end_x, end_y,
               brush_radius, draw_color, read_x, read_y,
        input  ready
    );
    modport sink (
        input  valid, req_type, start_x, start_y, end_x, end_y,
               brush_radius, draw_color, read_x, read_y,
        output ready
    );
endinterface

interface tlr_rsp_if;
    import tlr_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_value;
    logic               command_done;

    modport source (output valid, pixel_value, command_done, input ready);
    modport sink   (input valid, pixel_value, command_done, output ready);
endinterface

@@ rtl/tlr_ram.sv @@
module tlr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/thick_line_rasterizer.sv @@
// One pixel candidate per cycle while a line is drawn.
// One command at a time; the next can be taken in the cycle in which the result is posted.
// Throughput is set by the single write port of the image RAM.
// Reset (synchronous, active low) starts a zero fill of all 4096 pixels of the image;
// no item is accepted until it ends.
`include "thick_line_rasterizer_macros.svh"

module thick_line_rasterizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tlr_req_if.sink    i_req,
    tlr_rsp_if.source  o_rsp
);
    import tlr_pkg::*;

    t_state                     r_state, n_state;
    logic [ADDR_W-1:0]          r_cnt, n_cnt;
    logic [COORD_W-1:0]         r_wx, n_wx, r_wy, n_wy;
    logic [COORD_W-1:0]         r_ex, n_ex, r_ey, n_ey;
    logic [COORD_W-1:0]         r_adx, n_adx, r_ady, n_ady;
    logic                       r_sx, n_sx, r_sy, n_sy;
    logic signed [ERR_W-1:0]    r_err, n_err;
    logic [RAD_W-1:0]           r_rad, n_rad;
    logic [SQ_W-1:0]            r_rsq, n_rsq;
    logic signed [OFS_W-1:0]    r_ox, n_ox, r_oy, n_oy;
    logic [COLOR_W-1:0]         r_color, n_color;
    logic [COLOR_W-1:0]         r_val, n_val;
    logic                       r_rd_ok, n_rd_ok;
    logic                       r_out_valid, n_out_valid;
    logic [COLOR_W-1:0]         r_out_value, n_out_value;

    logic                       w_acc;
    logic                       w_out_free;
    logic                       w_cnt_last;
    logic signed [OFS_W-1:0]    w_rad_s, w_rad_neg;
    logic                       w_last_ox, w_last_oy, w_disc_last, w_end;
    logic signed [PIX_W-1:0]    w_px, w_py;
    logic                       w_in_img, w_hit;
    logic [ADDR_W-1:0]          w_pix_addr, w_rd_addr;
    logic                       w_rd_ok;
    logic signed [ERR_W:0]      w_twice, w_adx_s, w_ndy_s, w_err_sum;
    logic                       w_xstep, w_ystep;
    logic [COORD_W-1:0]         w_in_adx, w_in_ady;
    logic [RAD_W-1:0]           w_in_rad;
    logic                       w_we;
    logic [ADDR_W-1:0]          w_waddr;
    logic [COLOR_W-1:0]         w_wdata, w_rdata;

    tlr_ram #(.WIDTH(COLOR_W), .DEPTH(PIX_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata)
    );

    assign i_req.ready        = (r_state == S_IDLE);
    assign w_acc              = i_req.valid && i_req.ready;
    assign w_out_free         = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.pixel_value  = r_out_value;
    assign o_rsp.command_done = 1'b1;

    assign w_cnt_last = (r_cnt == ADDR_W'(PIX_DEPTH - 1));

    // disc scan
    assign w_rad_s     = signed'(OFS_W'(r_rad));
    assign w_rad_neg   = -w_rad_s;
    assign w_last_ox   = (r_ox == w_rad_s);
    assign w_last_oy   = (r_oy == w_rad_s);
    assign w_disc_last = w_last_ox && w_last_oy;
    assign w_end       = (r_wx == r_ex) && (r_wy == r_ey);
    assign w_px        = signed'(PIX_W'(r_wx)) + PIX_W'(r_ox);
    assign w_py        = signed'(PIX_W'(r_wy)) + PIX_W'(r_oy);
    assign w_in_img    = (w_px >= 0) && (w_px < PIX_W'(IMAGE_SIDE))
                      && (w_py >= 0) && (w_py < PIX_W'(IMAGE_SIDE));
    assign w_hit       = (f_square(r_ox) + f_square(r_oy)) <= r_rsq;
    assign w_pix_addr  = ADDR_W'(int'(w_py) * IMAGE_SIDE + int'(w_px));

    // Bresenham step
    assign w_twice   = signed'({r_err, 1'b0});
    assign w_adx_s   = signed'((ERR_W+1)'(r_adx));
    assign w_ndy_s   = -signed'((ERR_W+1)'(r_ady));
    assign w_xstep   = (w_twice >= w_ndy_s);
    assign w_ystep   = (w_twice <= w_adx_s);
    assign w_err_sum = (ERR_W+1)'(r_err)
                     + (w_xstep ? w_ndy_s : '0)
                     + (w_ystep ? w_adx_s : '0);

    // command decode
    assign w_in_adx = (i_req.end_x > i_req.start_x) ? i_req.end_x - i_req.start_x
                                                    : i_req.start_x - i_req.end_x;
    assign w_in_ady = (i_req.end_y > i_req.start_y) ? i_req.end_y - i_req.start_y
                                                    : i_req.start_y - i_req.end_y;
    assign w_in_rad = (int'(i_req.brush_radius) > MAX_BRUSH_RADIUS)
                    ? RAD_W'(MAX_BRUSH_RADIUS) : RAD_W'(i_req.brush_radius);
    assign w_rd_ok  = (int'(i_req.read_x) < IMAGE_SIDE) && (int'(i_req.read_y) < IMAGE_SIDE);
    assign w_rd_addr = ADDR_W'(int'(i_req.read_y) * IMAGE_SIDE + int'(i_req.read_x));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_WIPE: begin
                if (w_cnt_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_acc) begin
                    unique case (i_req.req_type)
                        REQ_CLEAR: n_state = S_CLEAR;
                        REQ_LINE:  n_state = S_DISC;
                        REQ_READ:  n_state = S_READ;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                if (w_cnt_last) n_state = S_DONE;
            end
            S_DISC: begin
                if (w_disc_last && w_end) n_state = S_DONE;
            end
            S_READ: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_WIPE;
        endcase
    end

    // RAM write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt;
        w_wdata = '0;
        unique case (r_state)
            S_WIPE, S_CLEAR: w_we = 1'b1;
            S_DISC: begin
                w_we    = w_hit && w_in_img;
                w_waddr = w_pix_addr;
                w_wdata = r_color;
            end
            default: w_we = 1'b0;
        endcase
    end

    // datapath
    always_comb begin
        n_cnt       = r_cnt;
        n_wx        = r_wx;
        n_wy        = r_wy;
        n_ex        = r_ex;
        n_ey        = r_ey;
        n_adx       = r_adx;
        n_ady       = r_ady;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_err       = r_err;
        n_rad       = r_rad;
        n_rsq       = r_rsq;
        n_ox        = r_ox;
        n_oy        = r_oy;
        n_color     = r_color;
        n_val       = r_val;
        n_rd_ok     = r_rd_ok;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_value = r_out_value;
        unique case (r_state)
            S_WIPE, S_CLEAR: n_cnt = r_cnt + 1'b1;
            S_IDLE: begin
                n_cnt   = '0;
                n_val   = '0;
                n_rd_ok = w_rd_ok;
                if (w_acc && i_req.req_type == REQ_LINE) begin
                    n_wx    = i_req.start_x;
                    n_wy    = i_req.start_y;
                    n_ex    = i_req.end_x;
                    n_ey    = i_req.end_y;
                    n_adx   = w_in_adx;
                    n_ady   = w_in_ady;
                    n_sx    = i_req.start_x < i_req.end_x;
                    n_sy    = i_req.start_y < i_req.end_y;
                    n_err   = signed'(ERR_W'(w_in_adx)) - signed'(ERR_W'(w_in_ady));
                    n_rad   = w_in_rad;
                    n_rsq   = SQ_W'(w_in_rad) * SQ_W'(w_in_rad);
                    n_ox    = -signed'(OFS_W'(w_in_rad));
                    n_oy    = -signed'(OFS_W'(w_in_rad));
                    n_color = i_req.draw_color;
                end
            end
            S_DISC: begin
                if (w_last_ox) begin
                    n_ox = w_rad_neg;
                    if (w_last_oy) begin
                        n_oy = w_rad_neg;
                        if (!w_end) begin
                            n_err = ERR_W'(w_err_sum);
                            if (w_xstep) n_wx = r_sx ? r_wx + 1'b1 : r_wx - 1'b1;
                            if (w_ystep) n_wy = r_sy ? r_wy + 1'b1 : r_wy - 1'b1;
                        end
                    end else begin
                        n_oy = r_oy + 1'b1;
                    end
                end else begin
                    n_ox = r_ox + 1'b1;
                end
            end
            S_READ: n_val = r_rd_ok ? w_rdata : '0;
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_val;
                end
            end
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WIPE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wx        <= n_wx;
        r_wy        <= n_wy;
        r_ex        <= n_ex;
        r_ey        <= n_ey;
        r_adx       <= n_adx;
        r_ady       <= n_ady;
        r_sx        <= n_sx;
        r_sy        <= n_sy;
        r_err       <= n_err;
        r_rad       <= n_rad;
        r_rsq       <= n_rsq;
        r_ox        <= n_ox;
        r_oy        <= n_oy;
        r_color     <= n_color;
        r_val       <= n_val;
        r_rd_ok     <= n_rd_ok;
        r_out_value <= n_out_value;
    end

    `TLR_ASSERT_NEXT(a_accept_busy, w_acc, r_state != S_IDLE, "item accepted but still idle")
    `TLR_ASSERT(a_disc_range, (r_state == S_DISC) |-> (r_ox >= w_rad_neg && r_ox <= w_rad_s && r_oy >= w_rad_neg && r_oy <= w_rad_s), "disc offset out of radius")
    `TLR_ASSERT(a_read_no_write, (r_state == S_READ || r_state == S_IDLE) |-> !w_we, "pixel write outside a fill or line")
    `TLR_ASSERT_NEXT(a_done_posts, r_state == S_DONE && w_out_free, r_out_valid && r_state == S_IDLE, "result not posted")

endmodule

@@ sim/testbench.sv @@
module testbench;
    import tlr_pkg::*;

    localparam logic [REQ_W-1:0] REQ_BOGUS = 2'd3;
    localparam int RANDOM_ITEMS = 117;
    localparam int IDLE_PCT     = 28;
    localparam int HOLD_CYCLES  = 130000;
    localparam int TAIL_CYCLES  = 20;
    localparam int DRAIN_LIMIT  = 300000;

    typedef struct {
        logic [REQ_W-1:0]    kind;
        logic [COORD_W-1:0]  sx;
        logic [COORD_W-1:0]  sy;
        logic [COORD_W-1:0]  ex;
        logic [COORD_W-1:0]  ey;
        logic [RAD_IN_W-1:0] rad;
        logic [COLOR_W-1:0]  color;
        logic [COORD_W-1:0]  rx;
        logic [COORD_W-1:0]  ry;
    } t_cmd;

    typedef struct {
        t_cmd               cmd;
        bit                 fixed;
        logic [COLOR_W-1:0] fix_pix;
    } t_row;

    typedef struct {
        logic [COLOR_W-1:0] pix;
        logic               done;
    } t_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tlr_req_if req_bus ();
    tlr_rsp_if rsp_bus ();

    thick_line_rasterizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    logic [COLOR_W-1:0] canvas [PIX_DEPTH];
    int walk_x;
    int walk_y;
    int walk_err;

    t_rsp pixel_expect_q [$];
    t_row stim_rows [$];

    bit                 offer_fixed;
    logic [COLOR_W-1:0] offer_fix_pix;
    bit                 calm;
    bit                 hold_req;
    logic [COORD_W-1:0] last_sx, last_sy, last_ex, last_ey;

    int mismatches;
    int n_results;
    int n_line, n_read, n_clear, n_bogus;

    always #10 i_clk = ~i_clk;

    initial begin
        #600_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void plot(int x, int y, logic [COLOR_W-1:0] col);
        if (x >= 0 && y >= 0 && x < IMAGE_SIDE && y < IMAGE_SIDE) begin
            canvas[y * IMAGE_SIDE + x] = col;
        end
    endfunction

    function automatic void paint_line(t_cmd c);
        int x1, y1, adx, ady, sx, sy, ndy, twice, r;
        bit fin;
        x1 = int'(c.ex);
        y1 = int'(c.ey);
        adx = (x1 > int'(c.sx)) ? x1 - int'(c.sx) : int'(c.sx) - x1;
        ady = (y1 > int'(c.sy)) ? y1 - int'(c.sy) : int'(c.sy) - y1;
        sx = (int'(c.sx) < x1) ? 1 : -1;
        sy = (int'(c.sy) < y1) ? 1 : -1;
        ndy = -ady;
        r = int'(c.rad);
        if (r > MAX_BRUSH_RADIUS) begin
            r = MAX_BRUSH_RADIUS;
        end
        walk_x = int'(c.sx);
        walk_y = int'(c.sy);
        walk_err = adx + ndy;
        fin = 1'b0;
        while (!fin) begin
            for (int oy = -r; oy <= r; oy++) begin
                for (int ox = -r; ox <= r; ox++) begin
                    if (ox * ox + oy * oy <= r * r) begin
                        plot(walk_x + ox, walk_y + oy, c.color);
                    end
                end
            end
            if (walk_x == x1 && walk_y == y1) begin
                fin = 1'b1;
            end else begin
                twice = 2 * walk_err;
                if (twice >= ndy) begin
                    walk_err += ndy;
                    walk_x += sx;
                end
                if (twice <= adx) begin
                    walk_err += adx;
                    walk_y += sy;
                end
            end
        end
    endfunction

    function automatic logic [COLOR_W-1:0] apply_command(t_cmd c);
        logic [COLOR_W-1:0] val;
        val = '0;
        case (c.kind)
            REQ_CLEAR: begin
                for (int i = 0; i < PIX_DEPTH; i++) begin
                    canvas[i] = '0;
                end
            end
            REQ_LINE: begin
                paint_line(c);
            end
            REQ_READ: begin
                if (int'(c.rx) < IMAGE_SIDE && int'(c.ry) < IMAGE_SIDE) begin
                    val = canvas[int'(c.ry) * IMAGE_SIDE + int'(c.rx)];
                end
            end
            default: begin
            end
        endcase
        return val;
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        int p;
        c.kind  = REQ_BOGUS;
        c.sx    = COORD_W'($urandom);
        c.sy    = COORD_W'($urandom);
        c.ex    = COORD_W'($urandom);
        c.ey    = COORD_W'($urandom);
        c.rad   = RAD_IN_W'($urandom);
        c.color = COLOR_W'($urandom);
        c.rx    = COORD_W'($urandom);
        c.ry    = COORD_W'($urandom);
        p = $urandom_range(0, 99);
        if (p < 8) begin
            c.kind = REQ_CLEAR;
        end else if (p < 14) begin
            c.kind = REQ_BOGUS;
        end else if (p < 50) begin
            c.kind = REQ_LINE;
            if ($urandom_range(0, 99) < 15) begin
                c.ex = c.sx;
                c.ey = c.sy;
            end
            // keep most brushes small so the run stays short
            if ($urandom_range(0, 99) < 80) begin
                c.rad = RAD_IN_W'($urandom_range(0, 4));
            end
            last_sx = c.sx;
            last_sy = c.sy;
            last_ex = c.ex;
            last_ey = c.ey;
        end else begin
            c.kind = REQ_READ;
            if ($urandom_range(0, 99) < 70) begin
                c.rx = ($urandom_range(0, 1) ? last_sx : last_ex)
                       + COORD_W'($urandom_range(0, 8)) - COORD_W'(4);
                c.ry = ($urandom_range(0, 1) ? last_sy : last_ey)
                       + COORD_W'($urandom_range(0, 8)) - COORD_W'(4);
            end
        end
        return c;
    endfunction

    function automatic void add_row(logic [REQ_W-1:0] kind,
                                    int sx, int sy, int ex, int ey, int rad,
                                    logic [COLOR_W-1:0] color, int rx, int ry,
                                    bit fixed, logic [COLOR_W-1:0] fix_pix);
        t_row row;
        row.cmd = rand_cmd();
        row.cmd.kind = kind;
        if (kind == REQ_LINE) begin
            row.cmd.sx = COORD_W'(sx);
            row.cmd.sy = COORD_W'(sy);
            row.cmd.ex = COORD_W'(ex);
            row.cmd.ey = COORD_W'(ey);
            row.cmd.rad = RAD_IN_W'(rad);
            row.cmd.color = color;
        end
        if (kind == REQ_READ) begin
            row.cmd.rx = COORD_W'(rx);
            row.cmd.ry = COORD_W'(ry);
        end
        row.fixed = fixed;
        row.fix_pix = fix_pix;
        stim_rows.push_back(row);
    endfunction

    task automatic drive_item(t_cmd c, bit fixed, logic [COLOR_W-1:0] fix_pix);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            req_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.req_type     <= c.kind;
        req_bus.start_x      <= c.sx;
        req_bus.start_y      <= c.sy;
        req_bus.end_x        <= c.ex;
        req_bus.end_y        <= c.ey;
        req_bus.brush_radius <= c.rad;
        req_bus.draw_color   <= c.color;
        req_bus.read_x       <= c.rx;
        req_bus.read_y       <= c.ry;
        offer_fixed   = fixed;
        offer_fix_pix = fix_pix;
        do begin
            @(posedge i_clk);
        end while (req_bus.ready !== 1'b1);
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_rsp want, got;
        t_cmd c;
        logic [COLOR_W-1:0] p;
        if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.pix  = rsp_bus.pixel_value;
            got.done = rsp_bus.command_done;
            n_results++;
            if (pixel_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result pixel=%h done=%b", got.pix, got.done);
                end
            end else begin
                want = pixel_expect_q.pop_front();
                if (got.pix !== want.pix || got.done !== want.done) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: pixel exp %h got %h, done exp %b got %b",
                                 want.pix, got.pix, want.done, got.done);
                    end
                end
            end
        end
        if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            c.kind  = req_bus.req_type;
            c.sx    = req_bus.start_x;
            c.sy    = req_bus.start_y;
            c.ex    = req_bus.end_x;
            c.ey    = req_bus.end_y;
            c.rad   = req_bus.brush_radius;
            c.color = req_bus.draw_color;
            c.rx    = req_bus.read_x;
            c.ry    = req_bus.read_y;
            case (c.kind)
                REQ_CLEAR: n_clear++;
                REQ_LINE:  n_line++;
                REQ_READ:  n_read++;
                default:   n_bogus++;
            endcase
            p = apply_command(c);
            want.pix  = offer_fixed ? offer_fix_pix : p;
            want.done = 1'b1;
            pixel_expect_q.push_back(want);
        end
    end

    initial begin : sink_side
        int hold_left;
        hold_left = 0;
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                rsp_bus.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin : source_side
        t_cmd c;
        int guard;
        req_bus.valid        = 1'b0;
        req_bus.req_type     = REQ_CLEAR;
        req_bus.start_x      = '0;
        req_bus.start_y      = '0;
        req_bus.end_x        = '0;
        req_bus.end_y        = '0;
        req_bus.brush_radius = '0;
        req_bus.draw_color   = '0;
        req_bus.read_x       = '0;
        req_bus.read_y       = '0;
        offer_fixed = 1'b0;
        offer_fix_pix = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        last_sx = '0;
        last_sy = '0;
        last_ex = '0;
        last_ey = '0;
        walk_x = 0;
        walk_y = 0;
        walk_err = 0;
        for (int i = 0; i < PIX_DEPTH; i++) begin
            canvas[i] = '0;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // store is zero after reset
        add_row(REQ_READ, 0, 0, 0, 0, 0, 16'h0000, 0, 0, 1, 16'h0000);
        add_row(REQ_READ, 0, 0, 0, 0, 0, 16'h0000, 63, 63, 1, 16'h0000);
        // single pixel, zero radius
        add_row(REQ_LINE, 0, 0, 0, 0, 0, 16'hFFFF, 0, 0, 1, 16'h0000);
        add_row(REQ_READ, 0, 0, 0, 0, 0, 16'h0000, 0, 0, 1, 16'hFFFF);
        add_row(REQ_READ, 0, 0, 0, 0, 0, 16'h0000, 1, 0, 1, 16'h0000);
        // widest disc in the corner, clipped at the border
        add_row(REQ_LINE, 63, 63, 63, 63, 15, 16'h1234, 0, 0, 1, 16'h0000);
        add_row(REQ_READ, 0, 0, 0, 0, 0, 16'h0000, 48, 63, 1, 16'h1234);
        add_row(REQ_READ, 0, 0, 0, 0, 0, 16'h0000, 47, 63, 1, 16'h0000);
        add_row(REQ_READ, 0, 0, 0, 0, 0, 16'h0000, 52, 52, 1, 16'h0000);
        // unknown request leaves the store alone
        add_row(REQ_BOGUS, 0, 0, 0, 0, 0, 16'h0000, 0, 0, 1, 16'h0000);
        add_row(REQ_READ, 0, 0, 0, 0, 0, 16'h0000, 63, 63, 1, 16'h1234);
        add_row(REQ_LINE, 0, 63, 63, 0, 1, 16'hAAAA, 0, 0, 0, 16'h0000);
        add_row(REQ_READ, 0, 0, 0, 0, 0, 16'h0000, 31, 32, 0, 16'h0000);
        add_row(REQ_LINE, 63, 0, 0, 0, 2, 16'h5555, 0, 0, 0, 16'h0000);
        add_row(REQ_READ, 0, 0, 0, 0, 0, 16'h0000, 30, 1, 0, 16'h0000);
        add_row(REQ_LINE, 10, 5, 10, 60, 3, 16'h0F0F, 0, 0, 0, 16'h0000);
        add_row(REQ_READ, 0, 0, 0, 0, 0, 16'h0000, 12, 33, 0, 16'h0000);
        add_row(REQ_LINE, 40, 20, 5, 7, 15, 16'hC3C3, 0, 0, 0, 16'h0000);
        add_row(REQ_READ, 0, 0, 0, 0, 0, 16'h0000, 20, 14, 0, 16'h0000);
        add_row(REQ_READ, 0, 0, 0, 0, 0, 16'h0000, 63, 0, 0, 16'h0000);
        add_row(REQ_CLEAR, 0, 0, 0, 0, 0, 16'h0000, 0, 0, 1, 16'h0000);
        add_row(REQ_READ, 0, 0, 0, 0, 0, 16'h0000, 31, 32, 1, 16'h0000);
        add_row(REQ_READ, 0, 0, 0, 0, 0, 16'h0000, 63, 63, 1, 16'h0000);

        foreach (stim_rows[i]) begin
            drive_item(stim_rows[i].cmd, stim_rows[i].fixed, stim_rows[i].fix_pix);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= 60 && i < 90);
            if (i == 100) begin
                @(negedge i_clk);
                req_bus.valid <= 1'b0;
                while (pixel_expect_q.size() != 0) @(posedge i_clk);
            end
            c = rand_cmd();
            drive_item(c, 1'b0, '0);
            if (i == 40) begin
                hold_req = 1'b1;
            end
        end
        calm = 1'b0;

        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        guard = 0;
        while (pixel_expect_q.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d line, %0d read, %0d clear and %0d unknown commands;",
                 n_line, n_read, n_clear, n_bogus);
        $display("%0d results checked, %0d mismatches, %0d still pending",
                 n_results, mismatches, pixel_expect_q.size());
        if (mismatches == 0 && pixel_expect_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/tlr_pkg.sv
rtl/tlr_if.sv
rtl/tlr_ram.sv
rtl/thick_line_rasterizer.sv
sim/testbench.sv
